[rtl/core/c2s_pkg.sv]
// Package for the cartesian to spherical converter.
// Holds shared constants, the item class struct and the CORDIC angle table.
// No dependencies.
package c2s_pkg;

   // Defaults for the top-level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Fixed-point scaling: coordinate plus fraction bits always make 32
   localparam int SCALE_BITS = 32;
   // CORDIC datapath and angle accumulator widths (2^31 = pi)
   localparam int CORD_W      = 40;
   localparam int ANG_W       = 36;
   localparam int CORD_STEPS  = 31;
   localparam int OUT_W       = 16;

   // Classification of one point, made by the front end
   typedef struct packed {
      logic zero;     // x = y = z = 0
      logic axis;     // x = y = 0
      logic z_neg;    // z below zero
   } c2s_class_type;

   // round(atan(2^-i) / pi * 2^31)
   function automatic logic signed [ANG_W-1:0] c2s_angle(input int idx);
      logic signed [ANG_W-1:0] val;
      begin
         case (idx)
            0:  val = 36'sd536870912;
            1:  val = 36'sd316933406;
            2:  val = 36'sd167458907;
            3:  val = 36'sd85004756;
            4:  val = 36'sd42667331;
            5:  val = 36'sd21354465;
            6:  val = 36'sd10679838;
            7:  val = 36'sd5340245;
            8:  val = 36'sd2670163;
            9:  val = 36'sd1335087;
            10: val = 36'sd667544;
            11: val = 36'sd333772;
            12: val = 36'sd166886;
            13: val = 36'sd83443;
            14: val = 36'sd41722;
            15: val = 36'sd20861;
            16: val = 36'sd10430;
            17: val = 36'sd5215;
            18: val = 36'sd2608;
            19: val = 36'sd1304;
            20: val = 36'sd652;
            21: val = 36'sd326;
            22: val = 36'sd163;
            23: val = 36'sd81;
            24: val = 36'sd41;
            25: val = 36'sd20;
            26: val = 36'sd10;
            27: val = 36'sd5;
            28: val = 36'sd3;
            29: val = 36'sd1;
            30: val = 36'sd1;
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

[rtl/core/c2s_front.sv]
// Front end: takes the point, forms magnitudes and classifies it.
// Depends on c2s_pkg.
module c2s_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic [COORD_WIDTH-1:0] x_coord,
   input  logic [COORD_WIDTH-1:0] y_coord,
   input  logic [COORD_WIDTH-1:0] z_coord,
   output logic [COORD_WIDTH-1:0] x_abs,
   output logic [COORD_WIDTH-1:0] y_abs,
   output logic [COORD_WIDTH-1:0] z_abs,
   output c2s_pkg::c2s_class_type cls
);
   import c2s_pkg::*;

   // magnitudes; the most negative value maps to 2^(W-1), which still fits
   assign x_abs = x_coord[COORD_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
   assign y_abs = y_coord[COORD_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;
   assign z_abs = z_coord[COORD_WIDTH-1] ? (~z_coord + 1'b1) : z_coord;

   // special cases
   always_comb begin
      cls.axis  = (x_coord == '0) && (y_coord == '0);
      cls.zero  = cls.axis && (z_coord == '0);
      cls.z_neg = z_coord[COORD_WIDTH-1];
   end
endmodule

[rtl/core/c2s_queue.sv]
// Short queue between front and back end.
// No dependencies; generic width and depth.
module c2s_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign valid     = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

[rtl/core/c2s_back.sv]
// Back end: squares, two pipelined square roots, two pipelined CORDICs
// and the output register. Whole pipeline advances when the output slot frees.
// Depends on c2s_pkg.
module c2s_back #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   output logic                           q_pop,
   input  logic [COORD_WIDTH-1:0]         x_coord,
   input  logic [COORD_WIDTH-1:0]         y_coord,
   input  logic [COORD_WIDTH-1:0]         z_coord,
   input  logic [COORD_WIDTH-1:0]         x_abs,
   input  logic [COORD_WIDTH-1:0]         y_abs,
   input  logic [COORD_WIDTH-1:0]         z_abs,
   input  c2s_pkg::c2s_class_type         cls,
   output logic                           out_valid,
   input  logic                           out_pop,
   output logic [c2s_pkg::OUT_W-1:0]      radius,
   output logic [c2s_pkg::OUT_W-1:0]      azimuth,
   output logic [c2s_pkg::OUT_W-1:0]      polar_angle,
   output logic                           zero_vector
);
   import c2s_pkg::*;

   localparam int W       = COORD_WIDTH;
   localparam int FRAC    = SCALE_BITS - W;
   localparam int NW      = 2 * SCALE_BITS;
   localparam int SQ_STEPS = NW / 2;
   localparam int ACC_HALF = 32768;

   logic advance;

   // ---------------- stage A: squares ----------------
   logic [2*W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic [W-1:0]    xa_ff, ya_ff, za_ff;
   c2s_class_type   cls_a_ff;
   logic            va_ff;

   // ---------------- square root pipeline ----------------
   logic [NW-1:0]   nr_ff [0:SQ_STEPS];
   logic [NW-1:0]   rr_ff [0:SQ_STEPS];
   logic [NW-1:0]   ns_ff [0:SQ_STEPS];
   logic [NW-1:0]   rs_ff [0:SQ_STEPS];
   logic [W-1:0]    xs_ff [0:SQ_STEPS];
   logic [W-1:0]    ys_ff [0:SQ_STEPS];
   logic [W-1:0]    zs_ff [0:SQ_STEPS];
   c2s_class_type   cls_s_ff [0:SQ_STEPS];
   logic            vs_ff [0:SQ_STEPS];

   // ---------------- CORDIC pipeline ----------------
   logic signed [CORD_W-1:0] pa_ff [0:CORD_STEPS];
   logic signed [CORD_W-1:0] pb_ff [0:CORD_STEPS];
   logic signed [ANG_W-1:0]  pc_ff [0:CORD_STEPS];
   logic signed [CORD_W-1:0] ta_ff [0:CORD_STEPS];
   logic signed [CORD_W-1:0] tb_ff [0:CORD_STEPS];
   logic signed [ANG_W-1:0]  tc_ff [0:CORD_STEPS];
   logic [OUT_W-1:0]         rad_c_ff [0:CORD_STEPS];
   c2s_class_type            cls_c_ff [0:CORD_STEPS];
   logic                     vc_ff [0:CORD_STEPS];

   // output slot
   logic                     out_v_ff;
   logic [OUT_W-1:0]         rad_out_ff, az_out_ff, pol_out_ff;
   logic                     zero_out_ff;

   assign advance     = !out_v_ff || out_pop;
   assign q_pop       = advance && q_valid;
   assign out_valid   = out_v_ff;
   assign radius      = rad_out_ff;
   assign azimuth     = az_out_ff;
   assign polar_angle = pol_out_ff;
   assign zero_vector = zero_out_ff;

   // stage A: one multiplier per coordinate
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff   <= x_abs * x_abs;
         sqy_ff   <= y_abs * y_abs;
         sqz_ff   <= z_abs * z_abs;
         xa_ff    <= x_coord;
         ya_ff    <= y_coord;
         za_ff    <= z_coord;
         cls_a_ff <= cls;
      end
   end

   // stage B: sums, fraction scaling for rho
   logic [NW-1:0] s2_in;
   assign s2_in = NW'(sqx_ff) + NW'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff[0] <= 1'b0;
      end else if (advance) begin
         vs_ff[0] <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nr_ff[0]    <= s2_in + NW'(sqz_ff);
         ns_ff[0]    <= s2_in << (2 * FRAC);
         rr_ff[0]    <= '0;
         rs_ff[0]    <= '0;
         xs_ff[0]    <= xa_ff;
         ys_ff[0]    <= ya_ff;
         zs_ff[0]    <= za_ff;
         cls_s_ff[0] <= cls_a_ff;
      end
   end

   // square root steps, one result bit pair per stage, for r and rho
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [NW-1:0] BITC = NW'(1) << (NW - 2 - 2 * k);
      logic [NW-1:0] nr_in, rr_in, ns_in, rs_in;

      always_comb begin
         if (nr_ff[k] >= rr_ff[k] + BITC) begin
            nr_in = nr_ff[k] - (rr_ff[k] + BITC);
            rr_in = (rr_ff[k] >> 1) + BITC;
         end else begin
            nr_in = nr_ff[k];
            rr_in = rr_ff[k] >> 1;
         end
         if (ns_ff[k] >= rs_ff[k] + BITC) begin
            ns_in = ns_ff[k] - (rs_ff[k] + BITC);
            rs_in = (rs_ff[k] >> 1) + BITC;
         end else begin
            ns_in = ns_ff[k];
            rs_in = rs_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vs_ff[k+1] <= vs_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            nr_ff[k+1]    <= nr_in;
            rr_ff[k+1]    <= rr_in;
            ns_ff[k+1]    <= ns_in;
            rs_ff[k+1]    <= rs_in;
            xs_ff[k+1]    <= xs_ff[k];
            ys_ff[k+1]    <= ys_ff[k];
            zs_ff[k+1]    <= zs_ff[k];
            cls_s_ff[k+1] <= cls_s_ff[k];
         end
      end
   end

   // pre-rotation into the right half plane, radius saturation
   logic signed [CORD_W-1:0] px_in, py_in, tz_in, trho_in;
   logic signed [CORD_W-1:0] pa_in, pb_in, ta_in, tb_in;
   logic signed [ANG_W-1:0]  pc_in, tc_in;
   logic [OUT_W-1:0]         rad_in;

   always_comb begin
      px_in   = CORD_W'(signed'(xs_ff[SQ_STEPS]));
      py_in   = CORD_W'(signed'(ys_ff[SQ_STEPS]));
      tz_in   = CORD_W'(signed'(zs_ff[SQ_STEPS])) <<< FRAC;
      trho_in = signed'(rs_ff[SQ_STEPS][CORD_W-1:0]);
      pa_in = px_in;
      pb_in = py_in;
      pc_in = '0;
      if (px_in < 0) begin
         if (py_in >= 0) begin
            pa_in = py_in;
            pb_in = -px_in;
            pc_in = ANG_W'(1073741824);
         end else begin
            pa_in = -py_in;
            pb_in = px_in;
            pc_in = -ANG_W'(1073741824);
         end
      end
      ta_in = tz_in;
      tb_in = trho_in;
      tc_in = '0;
      if (tz_in < 0) begin
         if (trho_in >= 0) begin
            ta_in = trho_in;
            tb_in = -tz_in;
            tc_in = ANG_W'(1073741824);
         end else begin
            ta_in = -trho_in;
            tb_in = tz_in;
            tc_in = -ANG_W'(1073741824);
         end
      end
      if (rr_ff[SQ_STEPS] > NW'(65535)) begin
         rad_in = '1;
      end else begin
         rad_in = rr_ff[SQ_STEPS][OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff[0] <= 1'b0;
      end else if (advance) begin
         vc_ff[0] <= vs_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff[0]    <= pa_in;
         pb_ff[0]    <= pb_in;
         pc_ff[0]    <= pc_in;
         ta_ff[0]    <= ta_in;
         tb_ff[0]    <= tb_in;
         tc_ff[0]    <= tc_in;
         rad_c_ff[0] <= rad_in;
         cls_c_ff[0] <= cls_s_ff[SQ_STEPS];
      end
   end

   // vectoring CORDIC steps for azimuth and polar angle
   for (genvar k = 0; k < CORD_STEPS; k++) begin : g_cordic
      logic signed [CORD_W-1:0] pa_in_k, pb_in_k, ta_in_k, tb_in_k;
      logic signed [ANG_W-1:0]  pc_in_k, tc_in_k;

      always_comb begin
         if (pb_ff[k] >= 0) begin
            pa_in_k = pa_ff[k] + (pb_ff[k] >>> k);
            pb_in_k = pb_ff[k] - (pa_ff[k] >>> k);
            pc_in_k = pc_ff[k] + c2s_angle(k);
         end else begin
            pa_in_k = pa_ff[k] - (pb_ff[k] >>> k);
            pb_in_k = pb_ff[k] + (pa_ff[k] >>> k);
            pc_in_k = pc_ff[k] - c2s_angle(k);
         end
         if (tb_ff[k] >= 0) begin
            ta_in_k = ta_ff[k] + (tb_ff[k] >>> k);
            tb_in_k = tb_ff[k] - (ta_ff[k] >>> k);
            tc_in_k = tc_ff[k] + c2s_angle(k);
         end else begin
            ta_in_k = ta_ff[k] - (tb_ff[k] >>> k);
            tb_in_k = tb_ff[k] + (ta_ff[k] >>> k);
            tc_in_k = tc_ff[k] - c2s_angle(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vc_ff[k+1] <= vc_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pa_ff[k+1]    <= pa_in_k;
            pb_ff[k+1]    <= pb_in_k;
            pc_ff[k+1]    <= pc_in_k;
            ta_ff[k+1]    <= ta_in_k;
            tb_ff[k+1]    <= tb_in_k;
            tc_ff[k+1]    <= tc_in_k;
            rad_c_ff[k+1] <= rad_c_ff[k];
            cls_c_ff[k+1] <= cls_c_ff[k];
         end
      end
   end

   // rounding to the 32768 = pi scale, clamps and special cases
   logic signed [ANG_W-1:0] phi_rnd, th_rnd;
   logic signed [ANG_W-1:0] phi_clp, th_clp;
   logic [OUT_W-1:0]        az_in, pol_in;
   c2s_class_type           cls_f;

   always_comb begin
      cls_f   = cls_c_ff[CORD_STEPS];
      phi_rnd = (pc_ff[CORD_STEPS] + ANG_W'(ACC_HALF)) >>> 16;
      th_rnd  = (tc_ff[CORD_STEPS] + ANG_W'(ACC_HALF)) >>> 16;
      phi_clp = phi_rnd;
      if (phi_rnd > ANG_W'(ACC_HALF)) begin
         phi_clp = ANG_W'(ACC_HALF);
      end else if (phi_rnd < -ANG_W'(ACC_HALF)) begin
         phi_clp = -ANG_W'(ACC_HALF);
      end
      th_clp = th_rnd;
      if (th_rnd > ANG_W'(ACC_HALF)) begin
         th_clp = ANG_W'(ACC_HALF);
      end else if (th_rnd < 0) begin
         th_clp = '0;
      end
      // +pi wraps onto -pi in 16 signed bits
      az_in  = phi_clp[OUT_W-1:0];
      pol_in = th_clp[OUT_W-1:0];
      if (cls_f.axis) begin
         az_in  = '0;
         pol_in = (!cls_f.zero && cls_f.z_neg) ? OUT_W'(ACC_HALF) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= vc_ff[CORD_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_out_ff  <= rad_c_ff[CORD_STEPS];
         az_out_ff   <= az_in;
         pol_out_ff  <= pol_in;
         zero_out_ff <= cls_f.zero;
      end
   end
endmodule

[rtl/core/cartesian_to_spherical.sv]
// Cartesian to spherical converter: radius, azimuth and polar angle of a point.
// A queued beat passes the square, sum, root, pre-rotation, CORDIC and output registers.
// Throughput: one point per cycle; set by the 32-step root and 31-step CORDIC pipes.
// The back pipeline stalls as a whole while the result slot holds an untaken beat.
// Reset (synchronous) empties the queue and the pipeline; no clearing pass.
module cartesian_to_spherical #(
   parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH_DEF,
   parameter int QUEUE_DEPTH = c2s_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [COORD_WIDTH-1:0]    req_x_coord,
   input  logic [COORD_WIDTH-1:0]    req_y_coord,
   input  logic [COORD_WIDTH-1:0]    req_z_coord,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [c2s_pkg::OUT_W-1:0] rsp_radius,
   output logic [c2s_pkg::OUT_W-1:0] rsp_azimuth,
   output logic [c2s_pkg::OUT_W-1:0] rsp_polar_angle,
   output logic                      rsp_zero_vector
);
   import c2s_pkg::*;

   localparam int CLS_W   = $bits(c2s_class_type);
   localparam int ENTRY_W = 6 * COORD_WIDTH + CLS_W;

   logic [COORD_WIDTH-1:0] x_abs, y_abs, z_abs;
   c2s_class_type          f_cls, b_cls;
   logic [ENTRY_W-1:0]     push_data, head_data;
   logic                   q_valid, q_pop, out_valid;
   logic [COORD_WIDTH-1:0] hx, hy, hz, hax, hay, haz;

   // classify
   c2s_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .x_coord (req_x_coord),
      .y_coord (req_y_coord),
      .z_coord (req_z_coord),
      .x_abs   (x_abs),
      .y_abs   (y_abs),
      .z_abs   (z_abs),
      .cls     (f_cls)
   );

   assign push_data = {req_x_coord, req_y_coord, req_z_coord, x_abs, y_abs, z_abs, f_cls};

   // decoupling queue
   c2s_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (push_data),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_data (head_data)
   );

   assign {hx, hy, hz, hax, hay, haz, b_cls} = head_data;

   // compute
   c2s_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .x_coord     (hx),
      .y_coord     (hy),
      .z_coord     (hz),
      .x_abs       (hax),
      .y_abs       (hay),
      .z_abs       (haz),
      .cls         (b_cls),
      .out_valid   (out_valid),
      .out_pop     (rsp_pop),
      .radius      (rsp_radius),
      .azimuth     (rsp_azimuth),
      .polar_angle (rsp_polar_angle),
      .zero_vector (rsp_zero_vector)
   );

   assign rsp_empty = !out_valid;
endmodule

[rtl/core/c2s_checker.sv]
// Port-level checks for the cartesian to spherical converter.
// Bound onto the top level; depends on nothing else.
module c2s_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_radius,
   input logic [15:0] rsp_azimuth,
   input logic [15:0] rsp_polar_angle,
   input logic        rsp_zero_vector
);
   // reset leaves no result beat
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // zero vector carries zero radius and angles
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_zero_vector) |->
         (rsp_radius == 16'd0 && rsp_azimuth == 16'd0 && rsp_polar_angle == 16'd0))
      else $error("zero vector with nonzero fields");

   // polar angle never beyond pi
   a_polar_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_polar_angle <= 16'd32768))
      else $error("polar angle out of range");

   // an untaken beat stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_radius)
         && $stable(rsp_azimuth) && $stable(rsp_polar_angle)))
      else $error("result changed while stalled");
endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_radius      (rsp_radius),
   .rsp_azimuth     (rsp_azimuth),
   .rsp_polar_angle (rsp_polar_angle),
   .rsp_zero_vector (rsp_zero_vector)
);
